>>> hdl/pfa_pkg.sv
// partition fit allocator: shared types and constants
// used by partition_fit_allocator; no dependencies
package pfa_pkg;

    // fixed widths of the transfer fields
    localparam int FUNC_W   = 1;
    localparam int ENTRY_W  = 7;
    localparam int AMOUNT_W = 8;
    localparam int AGE_W    = 5;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int POLICY_W   = 2;
    localparam int HOLD_W     = 4;
    localparam int PIU_W      = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTS_USED = 2'd2;

    // register reset values
    localparam logic [POLICY_W-1:0] POLICY_RST = 2'd0;
    localparam logic [HOLD_W-1:0]   HOLD_RST   = 4'd5;
    localparam logic [PIU_W-1:0]    PIU_RST    = 8'd0;

    // fit policy codes; any other code behaves as first fit
    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

    // item function codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_GRANT,
        ST_DONE
    } state_t;

endpackage

>>> hdl/pfa_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module pfa_ram #(
    parameter int WIDTH = 29,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/partition_fit_allocator.sv
// partition fit allocator: top level with walk sequencer and entry table
// depends on pfa_pkg and pfa_ram
// load: result registers, then output registers; allocate: table walk, grant write when an
// entry fits, then output registers; walk length = min(partitions_in_use, MAX_PARTITIONS),
// shorter under first fit at its pick; one entry per cycle through the single ram read port;
// next input transfer after the result is loaded for output; reset clears every entry with no
// input transfer meanwhile; configuration writes are taken at any time, also while clearing
module partition_fit_allocator #(
    parameter int MAX_PARTITIONS = 128,
    parameter int SIZE_BITS      = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [pfa_pkg::FUNC_W-1:0]      s_func,
    input  logic [pfa_pkg::ENTRY_W-1:0]     s_entry_index,
    input  logic [pfa_pkg::AMOUNT_W-1:0]    s_amount,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_granted,
    output logic [pfa_pkg::ENTRY_W-1:0]     m_chosen_entry,
    output logic [pfa_pkg::AMOUNT_W-1:0]    m_free_left,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W    = $clog2(MAX_PARTITIONS);
    localparam int CNT_W    = $clog2(MAX_PARTITIONS + 1);
    localparam int ENTRY_W  = pfa_pkg::ENTRY_W;
    localparam int AMOUNT_W = pfa_pkg::AMOUNT_W;
    localparam int AGE_W    = pfa_pkg::AGE_W;
    localparam int PIU_W    = pfa_pkg::PIU_W;
    localparam int LEN_W    = (CNT_W > PIU_W) ? CNT_W : PIU_W;
    localparam int EI_W     = (CNT_W > ENTRY_W) ? CNT_W : ENTRY_W;
    // table word: part size, free space, used space, age
    localparam int WORD_W   = 3 * SIZE_BITS + AGE_W;
    localparam int AGE_LO   = 0;
    localparam int USED_LO  = AGE_W;
    localparam int FREE_LO  = AGE_W + SIZE_BITS;
    localparam int PART_LO  = AGE_W + 2 * SIZE_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PARTITIONS - 1);

    pfa_pkg::state_t state_reg, state_next;

    logic [IDX_W-1:0]             clr_cnt_reg, clr_cnt_next;
    logic [pfa_pkg::POLICY_W-1:0] policy_reg;
    logic [pfa_pkg::HOLD_W-1:0]   hold_reg;
    logic [PIU_W-1:0]             piu_reg;

    logic [SIZE_BITS-1:0] amt_reg, amt_next;
    logic [CNT_W-1:0]     iss_cnt_reg, iss_cnt_next;
    logic                 vis_vld_reg, vis_vld_next;
    logic [IDX_W-1:0]     vis_idx_reg, vis_idx_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     pick_reg, pick_next;
    logic [SIZE_BITS-1:0] best_reg, best_next;
    logic [SIZE_BITS-1:0] pick_part_reg, pick_part_next;
    logic [SIZE_BITS-1:0] pick_used_reg, pick_used_next;
    logic [AGE_W-1:0]     pick_age_reg, pick_age_next;

    logic                 res_granted_reg, res_granted_next;
    logic [ENTRY_W-1:0]   res_entry_reg, res_entry_next;
    logic [AMOUNT_W-1:0]  res_free_reg, res_free_next;

    logic                 m_valid_reg, m_valid_next;
    logic                 m_granted_reg, m_granted_next;
    logic [ENTRY_W-1:0]   m_entry_reg, m_entry_next;
    logic [AMOUNT_W-1:0]  m_free_reg, m_free_next;

    // table ram ports
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    // decoded fields of the entry being visited
    logic [SIZE_BITS-1:0] ent_part, ent_free, ent_used;
    logic [AGE_W-1:0]     ent_age, age_inc;
    logic                 occupied, released, fits, cand, take, hit_stop;
    logic                 first_pol, iss_done, walk_end, s_xfer, load_ok;
    logic [LEN_W-1:0]     piu_ext, max_ext, len_sat;
    logic [CNT_W-1:0]     walk_len;
    logic [SIZE_BITS-1:0] amt_in, grant_free;
    logic [EI_W-1:0]      ei_ext;

    pfa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_PARTITIONS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // handshake and common terms
    assign s_ready  = (state_reg == pfa_pkg::ST_IDLE);
    assign s_xfer   = s_valid && s_ready;
    assign amt_in   = SIZE_BITS'(s_amount);
    assign ei_ext   = EI_W'(s_entry_index);
    assign load_ok  = (ei_ext < EI_W'(MAX_PARTITIONS));

    // walk length saturates at the table depth
    assign piu_ext  = LEN_W'(piu_reg);
    assign max_ext  = LEN_W'(MAX_PARTITIONS);
    assign len_sat  = (piu_ext > max_ext) ? max_ext : piu_ext;
    assign walk_len = CNT_W'(len_sat);
    assign iss_done = (iss_cnt_reg >= walk_len);

    // entry evaluation on the word read back from the table
    assign ent_part  = ram_rdata[PART_LO +: SIZE_BITS];
    assign ent_free  = ram_rdata[FREE_LO +: SIZE_BITS];
    assign ent_used  = ram_rdata[USED_LO +: SIZE_BITS];
    assign ent_age   = ram_rdata[AGE_LO +: AGE_W];
    assign age_inc   = ent_age + AGE_W'(1);
    assign occupied  = (ent_used != '0);
    assign released  = (age_inc > AGE_W'(hold_reg));
    assign fits      = (ent_free >= amt_reg);
    assign cand      = vis_vld_reg && !occupied && fits;
    assign first_pol = (policy_reg != pfa_pkg::POL_BEST) && (policy_reg != pfa_pkg::POL_WORST);
    assign take      = cand && (!found_reg
                       || ((policy_reg == pfa_pkg::POL_BEST) && (ent_free < best_reg))
                       || ((policy_reg == pfa_pkg::POL_WORST) && (ent_free > best_reg)));
    assign hit_stop  = cand && !found_reg && first_pol;
    assign walk_end  = hit_stop || (iss_done && !vis_vld_reg);
    assign grant_free = best_reg - amt_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pfa_pkg::ST_CLEAR: begin
                if (clr_cnt_reg == LAST_IDX) begin
                    state_next = pfa_pkg::ST_IDLE;
                end
            end
            pfa_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    if (s_func == pfa_pkg::FUNC_LOAD) begin
                        state_next = pfa_pkg::ST_DONE;
                    end else begin
                        state_next = pfa_pkg::ST_WALK;
                    end
                end
            end
            pfa_pkg::ST_WALK: begin
                if (walk_end) begin
                    if (found_reg || hit_stop) begin
                        state_next = pfa_pkg::ST_GRANT;
                    end else begin
                        state_next = pfa_pkg::ST_DONE;
                    end
                end
            end
            pfa_pkg::ST_GRANT: begin
                state_next = pfa_pkg::ST_DONE;
            end
            pfa_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = pfa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pfa_pkg::ST_CLEAR;
            end
        endcase
    end

    // datapath, table access and result registers
    always_comb begin
        clr_cnt_next     = clr_cnt_reg;
        amt_next         = amt_reg;
        iss_cnt_next     = iss_cnt_reg;
        vis_vld_next     = 1'b0;
        vis_idx_next     = vis_idx_reg;
        found_next       = found_reg;
        pick_next        = pick_reg;
        best_next        = best_reg;
        pick_part_next   = pick_part_reg;
        pick_used_next   = pick_used_reg;
        pick_age_next    = pick_age_reg;
        res_granted_next = res_granted_reg;
        res_entry_next   = res_entry_reg;
        res_free_next    = res_free_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_granted_next   = m_granted_reg;
        m_entry_next     = m_entry_reg;
        m_free_next      = m_free_reg;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = '0;
        ram_re           = 1'b0;
        ram_raddr        = iss_cnt_reg[IDX_W-1:0];
        case (state_reg)
            pfa_pkg::ST_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
            end
            pfa_pkg::ST_IDLE: begin
                amt_next     = amt_in;
                iss_cnt_next = '0;
                found_next   = 1'b0;
                if (s_xfer && (s_func == pfa_pkg::FUNC_LOAD)) begin
                    res_granted_next = 1'b0;
                    res_entry_next   = s_entry_index;
                    res_free_next    = '0;
                    if (load_ok) begin
                        ram_we        = 1'b1;
                        ram_waddr     = IDX_W'(s_entry_index);
                        ram_wdata     = {amt_in, amt_in, {SIZE_BITS{1'b0}}, {AGE_W{1'b0}}};
                        res_free_next = AMOUNT_W'(amt_in);
                    end
                end
            end
            pfa_pkg::ST_WALK: begin
                // issue the next read unless all reads are issued or the walk stops here
                if (!iss_done && !hit_stop) begin
                    ram_re       = 1'b1;
                    vis_vld_next = 1'b1;
                    vis_idx_next = iss_cnt_reg[IDX_W-1:0];
                    iss_cnt_next = iss_cnt_reg + CNT_W'(1);
                end
                // age or release an occupied entry
                if (vis_vld_reg && occupied) begin
                    ram_we    = 1'b1;
                    ram_waddr = vis_idx_reg;
                    if (released) begin
                        ram_wdata = {ent_part, ent_part, {SIZE_BITS{1'b0}}, {AGE_W{1'b0}}};
                    end else begin
                        ram_wdata = {ent_part, ent_free, ent_used, age_inc};
                    end
                end
                // track the policy pick
                if (take) begin
                    found_next     = 1'b1;
                    pick_next      = vis_idx_reg;
                    best_next      = ent_free;
                    pick_part_next = ent_part;
                    pick_used_next = ent_used;
                    pick_age_next  = ent_age;
                end
                if (walk_end) begin
                    res_granted_next = 1'b0;
                    res_entry_next   = '0;
                    res_free_next    = '0;
                end
            end
            pfa_pkg::ST_GRANT: begin
                ram_we           = 1'b1;
                ram_waddr        = pick_reg;
                ram_wdata        = {pick_part_reg, grant_free, pick_used_reg + amt_reg,
                                    pick_age_reg};
                res_granted_next = 1'b1;
                res_entry_next   = ENTRY_W'(pick_reg);
                res_free_next    = AMOUNT_W'(grant_free);
            end
            pfa_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_granted_next = res_granted_reg;
                    m_entry_next   = res_entry_reg;
                    m_free_next    = res_free_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pfa_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            vis_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            vis_vld_reg <= vis_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= pfa_pkg::POLICY_RST;
            hold_reg   <= pfa_pkg::HOLD_RST;
            piu_reg    <= pfa_pkg::PIU_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                pfa_pkg::CFG_FIT_POLICY: policy_reg <= cfg_data[pfa_pkg::POLICY_W-1:0];
                pfa_pkg::CFG_HOLD_LIMIT: hold_reg   <= cfg_data[pfa_pkg::HOLD_W-1:0];
                pfa_pkg::CFG_PARTS_USED: piu_reg    <= cfg_data[PIU_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        amt_reg         <= amt_next;
        iss_cnt_reg     <= iss_cnt_next;
        vis_idx_reg     <= vis_idx_next;
        found_reg       <= found_next;
        pick_reg        <= pick_next;
        best_reg        <= best_next;
        pick_part_reg   <= pick_part_next;
        pick_used_reg   <= pick_used_next;
        pick_age_reg    <= pick_age_next;
        res_granted_reg <= res_granted_next;
        res_entry_reg   <= res_entry_next;
        res_free_reg    <= res_free_next;
        m_granted_reg   <= m_granted_next;
        m_entry_reg     <= m_entry_next;
        m_free_reg      <= m_free_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_granted      = m_granted_reg;
    assign m_chosen_entry = m_entry_reg;
    assign m_free_left    = m_free_reg;

endmodule
